[design/osis_pkg.sv]
// Package for the ordered integer set store: sizes, codes, item types and value conversion.
package osis_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		MODE_INSERT   = 3'd0,
		MODE_REMOVE   = 3'd1,
		MODE_CONTAINS = 3'd2,
		MODE_READ     = 3'd3,
		MODE_CLEAR    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] read_value;
		logic [6:0]         entry_count;
		logic [1:0]         status;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic load;
		logic shift;
	} cell_ctrl_t;

	function automatic word_t to_word(logic signed [31:0] v);
		logic signed [VALUE_WIDTH-1:0] w;
		w = VALUE_WIDTH'(v);
		return word_t'(w);
	endfunction

	function automatic logic signed [31:0] from_word(word_t w);
		logic signed [VALUE_WIDTH-1:0] s;
		s = signed'(w);
		return 32'(s);
	endfunction

endpackage

[design/osis_cell.sv]
// One storage cell of the set: holds an entry, compares it with the key, shifts from its neighbor.
module osis_cell
	import osis_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  word_t      key,
	input  word_t      next_entry,
	output word_t      entry,
	output logic       match
);

	word_t entry_q;
	logic  match_q;

	always_ff @(posedge clk) begin
		match_q <= ctrl.valid && (entry_q == key);
		if (ctrl.load) begin
			entry_q <= key;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

[design/ordered_integer_set_store.sv]
// Top level of the ordered integer set store: control, count and the row of cells.
// Each item passes three states: the accept state, a compare state in which every
// cell registers its match against the key, and a resolve state that updates the
// cells and the count. The result is shown with done high for one cycle right
// after the resolve state; busy is low in that same cycle, so the next item can
// be started while done is high. The receiver cannot stall: take the result when
// done is high. Entries need no clearing after reset; only entries below the
// count are ever read.
module ordered_integer_set_store
	import osis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      done,
	output out_item_t result
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_RES  = 3'b100
	} state_t;

	state_t            state_q;
	logic [2:0]        mode_q;
	word_t             key_q;
	logic [5:0]        pos_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	out_item_t         result_q;

	cell_ctrl_t        ctrl    [CAPACITY];
	word_t             entry_w [CAPACITY];
	logic [CAPACITY-1:0] match_w;
	logic [CAPACITY-1:0] prefix;

	logic              hit;
	logic              full;
	logic              in_range;
	word_t             rd_word;
	logic              do_load;
	logic              do_shift;
	logic [CNT_W-1:0]  count_d;
	out_item_t         result_d;

	assign busy = (state_q != ST_IDLE);

	assign hit      = |match_w;
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign in_range = (32'(pos_q) < 32'(count_q));
	assign do_load  = (state_q == ST_RES) && (mode_q == MODE_INSERT) && !hit && !full;
	assign do_shift = (state_q == ST_RES) && (mode_q == MODE_REMOVE) && hit;

	always_comb begin
		logic [CAPACITY-1:0] ones;
		ones = '1;
		for (int i = 0; i < CAPACITY; i++) begin
			prefix[i] = |(match_w & (ones >> (CAPACITY - 1 - i)));
		end
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (32'(pos_q) == 32'(i)) begin
				rd_word = entry_w[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctrl[i].valid = (CNT_W'(i) < count_q);
			ctrl[i].load  = do_load && (count_q == CNT_W'(i));
			ctrl[i].shift = do_shift && prefix[i];
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			word_t nxt;
			if (g == CAPACITY - 1) begin : g_last
				assign nxt = entry_w[g];
			end else begin : g_mid
				assign nxt = entry_w[g+1];
			end
			osis_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[g]),
				.key        (key_q),
				.next_entry (nxt),
				.entry      (entry_w[g]),
				.match      (match_w[g])
			);
		end
	endgenerate

	always_comb begin
		count_d             = count_q;
		result_d.found      = 1'b0;
		result_d.read_value = '0;
		result_d.status     = STATUS_OK;
		unique case (mode_q)
			MODE_INSERT: begin
				if (hit) begin
					result_d.found = 1'b1;
				end else if (full) begin
					result_d.status = STATUS_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					result_d.found = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_CONTAINS: begin
				result_d.found = hit;
			end
			MODE_READ: begin
				if (in_range) begin
					result_d.read_value = from_word(rd_word);
				end else begin
					result_d.status = STATUS_RANGE;
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		result_d.entry_count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					state_q <= ST_IDLE;
					count_q <= count_d;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= cmd.mode;
			key_q  <= to_word(cmd.item_value);
			pos_q  <= cmd.position;
		end
		if (state_q == ST_RES) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
